@@ design/pf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pf_pkg;

    // Exponent field of one result item.
    localparam int EXP_BITS = 6;
    typedef logic [EXP_BITS-1:0] exp_t;

    // At most this many result items are given for one value; further
    // factors are dropped and the last one given carries the last flag.
    localparam int MAX_RESULTS = 11;
    localparam int NRES_BITS = 4;
    typedef logic [NRES_BITS-1:0] nres_t;

endpackage

`default_nettype wire

@@ design/prime_factorizer.sv @@
// After reset a clearing pass runs over the whole table, then a linear sieve fills it and
// lists the primes, trying listed primes on each table index; no item is taken before.
// Per item: trial division by listed primes, then table lookups, each division on the shared
// one-bit-a-cycle divider, then the result items and a finish step; a new item is taken once
// the previous last result is in the output. Reset (rst_n, asynchronous, active low) clears
// the state, sieve index, prime and result counts and valid flags and restarts the sieve.
`timescale 1ns / 1ps
`default_nettype none

module prime_factorizer #(
    parameter int TABLE_SIZE  = 1048576,
    parameter int PRIME_COUNT = 82025,
    parameter int VALUE_BITS  = 40
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // Input channel: one value per item.
    input  wire logic                    src_valid,
    output logic                         src_stall,
    input  wire logic [VALUE_BITS-1:0]   value,
    // Result channel: one prime with its exponent per item.
    output logic                         res_valid,
    input  wire logic                    res_stall,
    output logic [VALUE_BITS-1:0]        prime,
    output pf_pkg::exp_t                 exponent,
    output logic                         last,
    output logic                         empty_res
);

    // Widths that follow from the parameters.
    localparam int AW  = $clog2(TABLE_SIZE);          // table index and entry width
    localparam int PW  = $clog2(PRIME_COUNT);         // prime list index width
    localparam int CW  = $clog2(PRIME_COUNT + 1);     // prime count width
    localparam int VW  = VALUE_BITS;
    localparam int XW  = (2 * AW > VW) ? 2 * AW : VW; // common compare width
    localparam int DW  = $clog2(VW);                  // divider step counter

    localparam logic [AW-1:0]   LAST_IDX = AW'(TABLE_SIZE - 1);
    localparam logic [2*AW-1:0] N_PROD   = (2*AW)'(TABLE_SIZE);
    localparam logic [XW-1:0]   N_EXT    = XW'(TABLE_SIZE);
    localparam logic [CW-1:0]   PC_MAX   = CW'(PRIME_COUNT);
    localparam logic [DW-1:0]   DIV_TOP  = DW'(VW - 1);

    // Sequencer states: clearing pass, sieve, then factorization.
    localparam logic [4:0] C_CLR  = 5'd0;
    localparam logic [4:0] S_RDI  = 5'd1;
    localparam logic [4:0] S_CHK  = 5'd2;
    localparam logic [4:0] S_RDP  = 5'd3;
    localparam logic [4:0] S_MUL  = 5'd4;
    localparam logic [4:0] S_WR   = 5'd5;
    localparam logic [4:0] F_IDLE = 5'd6;
    localparam logic [4:0] F_TD   = 5'd7;
    localparam logic [4:0] F_TDP  = 5'd8;
    localparam logic [4:0] F_TDC  = 5'd9;
    localparam logic [4:0] F_DIV  = 5'd10;
    localparam logic [4:0] F_DIVE = 5'd11;
    localparam logic [4:0] F_TB   = 5'd12;
    localparam logic [4:0] F_TBR  = 5'd13;
    localparam logic [4:0] F_EMIT = 5'd14;
    localparam logic [4:0] F_FIN  = 5'd15;

    // The smallest-factor table and the prime list live in two synchronous memories,
    // each with one write and one read port, with registered read data.
    logic [AW-1:0] spf_mem [TABLE_SIZE];
    logic [AW-1:0] pl_mem  [PRIME_COUNT];
    logic [AW-1:0] spf_rdata_reg;
    logic [AW-1:0] pl_rdata_reg;

    logic          spf_we, spf_re, pl_we, pl_re;
    logic [AW-1:0] spf_waddr, spf_wdata, spf_raddr, pl_wdata;
    logic [PW-1:0] pl_waddr, pl_raddr;

    always_ff @(posedge clk)
    begin
        if (spf_we)
        begin
            spf_mem[spf_waddr] <= spf_wdata;
        end
        if (spf_re)
        begin
            spf_rdata_reg <= spf_mem[spf_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pl_we)
        begin
            pl_mem[pl_waddr] <= pl_wdata;
        end
        if (pl_re)
        begin
            pl_rdata_reg <= pl_mem[pl_raddr];
        end
    end

    // Control and datapath registers.
    logic [4:0]         state_reg, state_next, ret_reg, ret_next;
    logic [AW-1:0]      addr_reg, addr_next;     // clear address, then sieve index i
    logic [CW-1:0]      cnt_reg, cnt_next;       // primes listed so far
    logic [CW-1:0]      k_reg, k_next;           // prime list position
    logic [AW-1:0]      s_reg, s_next;           // smallest factor of i in the sieve
    logic [AW-1:0]      p_reg, p_next;           // current prime
    logic [2*AW-1:0]    prod_reg, prod_next;     // i*p in the sieve, p*p in trial division
    logic [VW-1:0]      v_reg, v_next;           // value still to be split
    logic [VW-1:0]      quo_reg, quo_next;
    logic [AW-1:0]      rem_reg, rem_next;
    logic [DW-1:0]      dcnt_reg, dcnt_next;
    pf_pkg::exp_t       e_reg, e_next;
    logic               trial_reg, trial_next;   // division belongs to trial phase
    logic [VW-1:0]      cand_p_reg, cand_p_next;
    pf_pkg::exp_t       cand_e_reg, cand_e_next;
    pf_pkg::nres_t      nres_reg, nres_next;

    // One result is held back so that the last flag can be set on it.
    logic               pend_valid_reg, pend_valid_next;
    logic [VW-1:0]      pend_p_reg, pend_p_next;
    pf_pkg::exp_t       pend_e_reg, pend_e_next;
    logic               pend_empty_reg, pend_empty_next;

    logic               out_valid_reg;
    logic               out_load;
    logic               out_last_next;
    logic [VW-1:0]      out_p_reg;
    pf_pkg::exp_t       out_e_reg;
    logic               out_last_reg, out_empty_reg;

    logic               out_free;
    logic [XW-1:0]      v_ext;
    logic [AW:0]        rem_sh;

    assign out_free = !out_valid_reg || !res_stall;
    assign v_ext    = XW'(v_reg);
    assign rem_sh   = {rem_reg, quo_reg[VW-1]};

    assign src_stall = (state_reg != F_IDLE);
    assign res_valid = out_valid_reg;
    assign prime     = out_p_reg;
    assign exponent  = out_e_reg;
    assign last      = out_last_reg;
    assign empty_res = out_empty_reg;

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        addr_next       = addr_reg;
        cnt_next        = cnt_reg;
        k_next          = k_reg;
        s_next          = s_reg;
        p_next          = p_reg;
        prod_next       = prod_reg;
        v_next          = v_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        dcnt_next       = dcnt_reg;
        e_next          = e_reg;
        trial_next      = trial_reg;
        cand_p_next     = cand_p_reg;
        cand_e_next     = cand_e_reg;
        nres_next       = nres_reg;
        pend_valid_next = pend_valid_reg;
        pend_p_next     = pend_p_reg;
        pend_e_next     = pend_e_reg;
        pend_empty_next = pend_empty_reg;
        out_load        = 1'b0;
        out_last_next   = 1'b0;
        spf_we          = 1'b0;
        spf_re          = 1'b0;
        spf_waddr       = addr_reg;
        spf_wdata       = '0;
        spf_raddr       = addr_reg;
        pl_we           = 1'b0;
        pl_re           = 1'b0;
        pl_waddr        = cnt_reg[PW-1:0];
        pl_wdata        = addr_reg;
        pl_raddr        = k_reg[PW-1:0];

        case (state_reg)
            C_CLR:
            begin
                spf_we = 1'b1;
                if (addr_reg == LAST_IDX)
                begin
                    addr_next  = AW'(2);
                    state_next = S_RDI;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end

            S_RDI:
            begin
                spf_re     = 1'b1;
                state_next = S_CHK;
            end

            S_CHK:
            begin
                // An unmarked entry is a prime: it marks itself and joins the list while it has room.
                if (spf_rdata_reg == '0)
                begin
                    s_next    = addr_reg;
                    spf_we    = 1'b1;
                    spf_wdata = addr_reg;
                    if (cnt_reg < PC_MAX)
                    begin
                        pl_we    = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                else
                begin
                    s_next = spf_rdata_reg;
                end
                k_next     = '0;
                state_next = S_RDP;
            end

            S_RDP:
            begin
                if (k_reg >= cnt_reg)
                begin
                    if (addr_reg == LAST_IDX)
                    begin
                        state_next = F_IDLE;
                    end
                    else
                    begin
                        addr_next  = addr_reg + 1'b1;
                        state_next = S_RDI;
                    end
                end
                else
                begin
                    pl_re      = 1'b1;
                    state_next = S_MUL;
                end
            end

            S_MUL:
            begin
                p_next     = pl_rdata_reg;
                prod_next  = addr_reg * pl_rdata_reg;
                state_next = S_WR;
            end

            S_WR:
            begin
                // The sieve for i stops once the product leaves the table, p reaches the
                // smallest factor of i or the listed primes run out.
                if (prod_reg >= N_PROD || p_reg == s_reg)
                begin
                    if (prod_reg < N_PROD)
                    begin
                        spf_we    = 1'b1;
                        spf_waddr = prod_reg[AW-1:0];
                        spf_wdata = p_reg;
                    end
                    if (addr_reg == LAST_IDX)
                    begin
                        state_next = F_IDLE;
                    end
                    else
                    begin
                        addr_next  = addr_reg + 1'b1;
                        state_next = S_RDI;
                    end
                end
                else
                begin
                    spf_we     = 1'b1;
                    spf_waddr  = prod_reg[AW-1:0];
                    spf_wdata  = p_reg;
                    k_next     = k_reg + 1'b1;
                    state_next = S_RDP;
                end
            end

            F_IDLE:
            begin
                if (src_valid)
                begin
                    v_next    = value;
                    k_next    = '0;
                    nres_next = '0;
                    if (value <= VW'(1))
                    begin
                        pend_valid_next = 1'b1;
                        pend_p_next     = '0;
                        pend_e_next     = '0;
                        pend_empty_next = 1'b1;
                        nres_next       = pf_pkg::nres_t'(1);
                        state_next      = F_FIN;
                    end
                    else
                    begin
                        state_next = F_TD;
                    end
                end
            end

            F_TD:
            begin
                if (k_reg >= cnt_reg || v_ext < N_EXT)
                begin
                    state_next = F_TB;
                end
                else
                begin
                    pl_re      = 1'b1;
                    state_next = F_TDP;
                end
            end

            F_TDP:
            begin
                p_next     = pl_rdata_reg;
                prod_next  = pl_rdata_reg * pl_rdata_reg;
                state_next = F_TDC;
            end

            F_TDC:
            begin
                if (XW'(prod_reg) > v_ext)
                begin
                    state_next = F_TB;
                end
                else
                begin
                    trial_next = 1'b1;
                    e_next     = '0;
                    quo_next   = v_reg;
                    rem_next   = '0;
                    dcnt_next  = DIV_TOP;
                    state_next = F_DIV;
                end
            end

            F_DIV:
            begin
                // Restoring division, one quotient bit a cycle.
                if (rem_sh >= {1'b0, p_reg})
                begin
                    rem_next = AW'(rem_sh - {1'b0, p_reg});
                    quo_next = {quo_reg[VW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[AW-1:0];
                    quo_next = {quo_reg[VW-2:0], 1'b0};
                end
                if (dcnt_reg == '0)
                begin
                    state_next = F_DIVE;
                end
                else
                begin
                    dcnt_next = dcnt_reg - 1'b1;
                end
            end

            F_DIVE:
            begin
                if (rem_reg == '0)
                begin
                    v_next     = quo_reg;
                    e_next     = e_reg + 1'b1;
                    rem_next   = '0;
                    dcnt_next  = DIV_TOP;
                    state_next = F_DIV;
                end
                else
                begin
                    cand_p_next = VW'(p_reg);
                    cand_e_next = e_reg;
                    if (trial_reg)
                    begin
                        k_next     = k_reg + 1'b1;
                        ret_next   = F_TD;
                        state_next = (e_reg != '0) ? F_EMIT : F_TD;
                    end
                    else
                    begin
                        ret_next   = F_TB;
                        state_next = F_EMIT;
                    end
                end
            end

            F_TB:
            begin
                if (v_ext > XW'(1) && v_ext < N_EXT)
                begin
                    spf_re     = 1'b1;
                    spf_raddr  = v_ext[AW-1:0];
                    state_next = F_TBR;
                end
                else if (v_ext > XW'(1))
                begin
                    // What is left over is taken as a prime.
                    cand_p_next = v_reg;
                    cand_e_next = pf_pkg::exp_t'(1);
                    ret_next    = F_FIN;
                    state_next  = F_EMIT;
                end
                else
                begin
                    state_next = F_FIN;
                end
            end

            F_TBR:
            begin
                if (spf_rdata_reg < AW'(2) || XW'(spf_rdata_reg) > v_ext)
                begin
                    p_next = v_ext[AW-1:0];
                end
                else
                begin
                    p_next = spf_rdata_reg;
                end
                trial_next = 1'b0;
                e_next     = '0;
                quo_next   = v_reg;
                rem_next   = '0;
                dcnt_next  = DIV_TOP;
                state_next = F_DIV;
            end

            F_EMIT:
            begin
                if (nres_reg >= pf_pkg::nres_t'(pf_pkg::MAX_RESULTS))
                begin
                    state_next = ret_reg;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    out_load        = pend_valid_reg;
                    pend_valid_next = 1'b1;
                    pend_p_next     = cand_p_reg;
                    pend_e_next     = cand_e_reg;
                    pend_empty_next = 1'b0;
                    nres_next       = nres_reg + 1'b1;
                    state_next      = ret_reg;
                end
            end

            F_FIN:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = F_IDLE;
                end
            end

            default:
            begin
                state_next = C_CLR;
                addr_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= C_CLR;
            addr_reg       <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            nres_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            nres_reg       <= nres_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ret_reg        <= ret_next;
        k_reg          <= k_next;
        s_reg          <= s_next;
        p_reg          <= p_next;
        prod_reg       <= prod_next;
        v_reg          <= v_next;
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        dcnt_reg       <= dcnt_next;
        e_reg          <= e_next;
        trial_reg      <= trial_next;
        cand_p_reg     <= cand_p_next;
        cand_e_reg     <= cand_e_next;
        pend_p_reg     <= pend_p_next;
        pend_e_reg     <= pend_e_next;
        pend_empty_reg <= pend_empty_next;
        if (out_load)
        begin
            out_p_reg     <= pend_p_reg;
            out_e_reg     <= pend_e_reg;
            out_last_reg  <= out_last_next;
            out_empty_reg <= pend_empty_reg;
        end
    end

    // No item is taken while the table is still being cleared or sieved.
    a_no_accept_in_sieve: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_CLR || state_reg == S_RDI || state_reg == S_CHK ||
         state_reg == S_RDP || state_reg == S_MUL || state_reg == S_WR) |-> src_stall)
        else $error("item accepted before the sieve finished");

    // An empty result is always the only and last one for its value.
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && empty_res) |-> (last && prime == '0 && exponent == '0))
        else $error("empty result without last flag");

    // A real factor is at least two.
    a_prime_min: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !empty_res) |-> (prime >= VW'(2)))
        else $error("result prime below two");

    // The result count never passes its limit.
    a_nres_cap: assert property (@(posedge clk) disable iff (!rst_n)
        nres_reg <= pf_pkg::nres_t'(pf_pkg::MAX_RESULTS))
        else $error("too many results for one item");

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    // Every legal value is factorized here by plain trial division.
    // Both the hardware's trial division and its table walk find the
    // primes in ascending order, so the expected sequence is simply the
    // ascending prime factorization.

    localparam int VBITS = 40;
    localparam longint unsigned TABLE_LIMIT = 64'd1 << 20;
    localparam longint unsigned VALUE_LIMIT = 64'd1 << VBITS;
    localparam longint unsigned CYCLE_LIMIT = 64'd60_000_000;

    typedef struct {
        logic [VBITS-1:0]   prime;
        pf_pkg::exp_t       exponent;
        logic               last;
        logic               empty_res;
    } factor_t;

    typedef struct {
        logic [VBITS-1:0]   value;
        bit                 drain_first;
    } job_t;

    logic                   clk;
    logic                   rst_n;
    logic                   src_valid;
    logic                   src_stall;
    logic [VBITS-1:0]       value;
    logic                   res_valid;
    logic                   res_stall;
    logic [VBITS-1:0]       prime;
    pf_pkg::exp_t           exponent;
    logic                   last;
    logic                   empty_res;

    job_t                   job_queue[$];
    factor_t                factors_due[$];
    int                     mismatches;
    int                     send_gap;
    int                     recv_gap;
    longint unsigned        cycle_count;

    prime_factorizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .value     (value),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .prime     (prime),
        .exponent  (exponent),
        .last      (last),
        .empty_res (empty_res)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Most gaps are short, now and then one is long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(20, 80);
    endfunction

    // Queue the factors of one accepted value.
    task automatic factorize(input logic [VBITS-1:0] v_in);
        longint unsigned rest;
        longint unsigned d;
        int              mult;
        int              count;
        factor_t         f;
        rest = v_in;
        count = 0;
        if (rest <= 1)
        begin
            f.prime = '0;
            f.exponent = '0;
            f.last = 1'b1;
            f.empty_res = 1'b1;
            factors_due = {factors_due, f};
        end
        else
        begin
            d = 2;
            while (d * d <= rest)
            begin
                mult = 0;
                while (rest % d == 0)
                begin
                    rest = rest / d;
                    mult++;
                end
                if (mult != 0 && count < pf_pkg::MAX_RESULTS)
                begin
                    f.prime = d[VBITS-1:0];
                    f.exponent = mult[pf_pkg::EXP_BITS-1:0];
                    f.last = 1'b0;
                    f.empty_res = 1'b0;
                    factors_due = {factors_due, f};
                    count++;
                end
                d = (d == 2) ? 3 : d + 2;
            end
            if (rest > 1 && count < pf_pkg::MAX_RESULTS)
            begin
                f.prime = rest[VBITS-1:0];
                f.exponent = 1;
                f.last = 1'b0;
                f.empty_res = 1'b0;
                factors_due = {factors_due, f};
            end
            factors_due[factors_due.size()-1].last = 1'b1;
        end
    endtask

    task automatic add_job(input longint unsigned v, input bit drain);
        job_t j;
        j.value = v[VBITS-1:0];
        j.drain_first = drain;
        job_queue = {job_queue, j};
    endtask

    // A large value built from small factors times an optional cofactor
    // below the table size, so trial division ends quickly.
    function automatic longint unsigned smooth_value();
        longint unsigned v;
        longint unsigned f;
        v = 1;
        do
        begin
            f = $urandom_range(2, 1023);
            if (v * f < VALUE_LIMIT)
                v = v * f;
        end
        while ($urandom_range(0, 7) != 0 && v < (VALUE_LIMIT >> 10));
        f = $urandom_range(2, TABLE_LIMIT - 1);
        if ($urandom_range(0, 1) && v * f < VALUE_LIMIT)
            v = v * f;
        return v;
    endfunction

    // Sender: holds an item until it is taken, then waits its gap.
    always @(posedge clk or negedge rst_n)
    begin
        job_t next_job;
        if (!rst_n)
        begin
            src_valid <= 1'b0;
            value <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (src_valid && !src_stall)
                factorize(value);
            if (!(src_valid && src_stall))
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    src_valid <= 1'b0;
                end
                else if (job_queue.size() > 0 &&
                         !(job_queue[0].drain_first && factors_due.size() > 0))
                begin
                    next_job = job_queue.pop_front();
                    src_valid <= 1'b1;
                    value <= next_job.value;
                    send_gap <= pick_gap();
                end
                else
                begin
                    src_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stall, checks each taken item against the oldest
    // expected factor.
    always @(posedge clk or negedge rst_n)
    begin
        factor_t f;
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            recv_gap <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (factors_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("Unexpected result item: prime=%0d exponent=%0d",
                                 prime, exponent);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    f = factors_due.pop_front();
                    if (prime !== f.prime || exponent !== f.exponent ||
                        last !== f.last || empty_res !== f.empty_res)
                    begin
                        if (mismatches < 10)
                            $display({"Mismatch: expected prime=%0d exp=%0d last=%b ",
                                      "empty=%b, got prime=%0d exp=%0d last=%b empty=%b"},
                                     f.prime, f.exponent, f.last, f.empty_res,
                                     prime, exponent, last, empty_res);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                res_stall <= 1'b1;
            end
            else
            begin
                recv_gap <= pick_gap();
                res_stall <= 1'b0;
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("prime_factorizer test failed");
            $finish;
        end
    end

    initial
    begin
        int roll;
        cycle_count = 0;
        rst_n = 1'b0;

        // Directed items: empty values, field extremes, powers, the table
        // boundary, large values with a big prime cofactor and the most
        // distinct primes that fit in the value width.
        add_job(0, 0);
        add_job(1, 0);
        add_job(2, 0);
        add_job(3, 0);
        add_job(4, 0);
        add_job(64, 0);
        add_job(1000000, 0);
        add_job(1048573, 0);
        add_job(TABLE_LIMIT - 1, 0);
        add_job(TABLE_LIMIT, 0);
        add_job(1048583, 0);
        add_job(2 * 64'd1048573, 0);
        add_job(VALUE_LIMIT - 1, 0);
        add_job(64'd1 << 39, 0);
        add_job(64'd847288609443, 0);
        add_job(64'd200560490130, 0);
        add_job(64'd1048573 * 64'd1024, 0);

        // Random items; one of them waits until every result has drained.
        for (int n = 0; n < 100; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
                add_job($urandom_range(0, 63), n == 50);
            else if (roll < 60)
                add_job($urandom_range(0, TABLE_LIMIT - 1), n == 50);
            else
                add_job(smooth_value(), n == 50);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (job_queue.size() > 0 || src_valid || factors_due.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (mismatches == 0 && factors_due.size() == 0)
            $display("prime_factorizer test passed");
        else
            $display("prime_factorizer test failed");
        $finish;
    end

endmodule

@@ files.f @@
design/pf_pkg.sv
design/prime_factorizer.sv
test/testbench.sv
